// ----- src/asde_pkg.sv -----
// Shared types and constants of the analog stick dead-zone event block.
`timescale 1ns / 1ps

package asde_pkg;

  localparam int RAW_W      = 8;
  localparam int DZ_W       = 14;
  localparam int OUT_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 14;

  localparam logic [DZ_W-1:0] DZ_RESET = 14'd2621;

  localparam logic [CFG_IDX_W-1:0] REG_DZ_LEFT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DZ_RIGHT = 1'b1;

  typedef enum logic [1:0] {
    EV_DOWN = 2'd0,
    EV_MOVE = 2'd1,
    EV_UP   = 2'd2
  } evt_kind_e;

  typedef struct packed {
    logic             stick_select;
    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
  } in_item_t;

  typedef struct packed {
    logic                    stick_out;
    logic signed [OUT_W-1:0] out_x;
    logic signed [OUT_W-1:0] out_y;
    evt_kind_e               event_kind;
  } out_item_t;

  // Work handed to the arithmetic engine for one sample.
  typedef struct packed {
    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
    logic [DZ_W-1:0]  dz;
  } eng_req_t;

  // Conditioned axis values returned by the engine.
  typedef struct packed {
    logic signed [OUT_W-1:0] out_x;
    logic signed [OUT_W-1:0] out_y;
  } eng_res_t;

endpackage

// ----- src/asde_stream_if.sv -----
// Valid/ready stream channel carrying one payload per transaction.
`timescale 1ns / 1ps

interface asde_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/asde_engine.sv -----
// Sequenced arithmetic engine: magnitude, dead-zone test and axis scaling.
`timescale 1ns / 1ps

module asde_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  asde_pkg::eng_req_t req_i,
  input  logic               ack_i,
  output logic               done_o,
  output asde_pkg::eng_res_t res_o
);
  import asde_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_MX   = 12'b0000_0000_0010,
    S_MY   = 12'b0000_0000_0100,
    S_SQI  = 12'b0000_0000_1000,
    S_SQRT = 12'b0000_0001_0000,
    S_MAG  = 12'b0000_0010_0000,
    S_DEN  = 12'b0000_0100_0000,
    S_NUM  = 12'b0000_1000_0000,
    S_PRE  = 12'b0001_0000_0000,
    S_DIV  = 12'b0010_0000_0000,
    S_AXD  = 12'b0100_0000_0000,
    S_DONE = 12'b1000_0000_0000
  } eng_state_e;

  localparam logic [29:0] SQ_BIT_INIT = 30'h1000_0000;
  localparam logic [14:0] Q_ONE       = 15'd16384;
  localparam logic [4:0]  DIV_LAST    = 5'd16;

  eng_state_e state_q, state_d;

  logic [7:0]  ax_q, ay_q;
  logic        negx_q, negy_q;
  logic [13:0] dz_q;
  logic [29:0] prod_q;
  logic [14:0] acc_q;
  logic [29:0] rem_q, res_q, bit_q;
  logic [14:0] md_q;
  logic [28:0] den_q;
  logic [43:0] n_q;
  logic [16:0] q_q;
  logic        sat_q;
  logic [4:0]  cnt_q;
  logic        axis_q;
  logic [15:0] ox_q, oy_q;

  logic [14:0] mul_a, mul_b;
  logic [29:0] mul_p;
  logic [29:0] sub_a, sub_b, sub_diff;
  logic [30:0] sub_full;
  logic        sub_ge;
  logic [29:0] trial;
  logic [14:0] mag;
  logic        pass;
  logic        neg_cur;
  logic [15:0] axis_val;

  assign trial = res_q + bit_q;
  assign mag   = res_q[14:0];
  assign pass  = (mag >= {1'b0, dz_q}) && (mag != 15'd0);

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MX: begin
        mul_a = {7'd0, ax_q};
        mul_b = {7'd0, ax_q};
      end
      S_MY: begin
        mul_a = {7'd0, ay_q};
        mul_b = {7'd0, ay_q};
      end
      S_MAG: begin
        mul_a = mag;
        mul_b = Q_ONE - {1'b0, dz_q};
      end
      S_DEN: begin
        mul_a = {7'd0, ax_q};
        mul_b = md_q;
      end
      S_AXD: begin
        mul_a = {7'd0, ay_q};
        mul_b = md_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Shared subtract-and-compare unit for square root and division steps.
  always_comb begin
    sub_a = '0;
    sub_b = '0;
    case (state_q)
      S_SQRT: begin
        sub_a = rem_q;
        sub_b = trial;
      end
      S_PRE: begin
        sub_a = {3'd0, n_q[43:17]};
        sub_b = {1'b0, den_q};
      end
      S_DIV: begin
        sub_a = {rem_q[28:0], n_q[16]};
        sub_b = {1'b0, den_q};
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  assign sub_full = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = ~sub_full[30];
  assign sub_diff = sub_full[29:0];

  // Sign and saturation of the finished quotient.
  assign neg_cur = axis_q ? negy_q : negx_q;
  always_comb begin
    if (neg_cur) begin
      if (sat_q || (q_q > 17'd32768)) begin
        axis_val = 16'h8000;
      end else begin
        axis_val = 16'(17'd0 - q_q);
      end
    end else begin
      if (sat_q || (q_q > 17'd32767)) begin
        axis_val = 16'h7FFF;
      end else begin
        axis_val = q_q[15:0];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (start_i) state_d = S_MX;
      S_MX:   state_d = S_MY;
      S_MY:   state_d = S_SQI;
      S_SQI:  state_d = S_SQRT;
      S_SQRT: if (bit_q[0]) state_d = S_MAG;
      S_MAG:  state_d = pass ? S_DEN : S_DONE;
      S_DEN:  state_d = S_NUM;
      S_NUM:  state_d = S_PRE;
      S_PRE:  state_d = sub_ge ? S_AXD : S_DIV;
      S_DIV:  if (cnt_q == 5'd0) state_d = S_AXD;
      S_AXD:  state_d = axis_q ? S_DONE : S_NUM;
      S_DONE: if (ack_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ax_q   <= req_i.raw_x[7] ? {1'b0, req_i.raw_x[6:0]} : 8'd128 - req_i.raw_x;
          ay_q   <= req_i.raw_y[7] ? {1'b0, req_i.raw_y[6:0]} : 8'd128 - req_i.raw_y;
          negx_q <= ~req_i.raw_x[7];
          negy_q <= ~req_i.raw_y[7];
          dz_q   <= req_i.dz;
          axis_q <= 1'b0;
        end
      end
      S_MX: begin
        prod_q <= mul_p;
      end
      S_MY: begin
        acc_q  <= prod_q[14:0];
        prod_q <= mul_p;
      end
      S_SQI: begin
        rem_q <= {({1'b0, acc_q} + {1'b0, prod_q[14:0]}), 14'd0};
        res_q <= '0;
        bit_q <= SQ_BIT_INIT;
      end
      S_SQRT: begin
        if (sub_ge) begin
          rem_q <= sub_diff;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      S_MAG: begin
        if (pass) begin
          md_q   <= mag - {1'b0, dz_q};
          prod_q <= mul_p;
        end else begin
          ox_q <= '0;
          oy_q <= '0;
        end
      end
      S_DEN: begin
        den_q  <= prod_q[28:0];
        prod_q <= mul_p;
      end
      S_NUM: begin
        // Numerator a * (M - D) << 21, plus half the divisor for rounding.
        n_q   <= {1'b0, prod_q[21:0], 21'd0} + {16'd0, den_q[28:1]};
        sat_q <= 1'b0;
        q_q   <= '0;
      end
      S_PRE: begin
        if (sub_ge) begin
          sat_q <= 1'b1;
        end else begin
          rem_q <= sub_a;
        end
        cnt_q <= DIV_LAST;
      end
      S_DIV: begin
        rem_q <= sub_ge ? sub_diff : sub_a;
        q_q   <= {q_q[15:0], sub_ge};
        n_q   <= n_q << 1;
        cnt_q <= cnt_q - 5'd1;
      end
      S_AXD: begin
        if (axis_q) begin
          oy_q <= axis_val;
        end else begin
          ox_q   <= axis_val;
          prod_q <= mul_p;
          axis_q <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign done_o       = (state_q == S_DONE);
  assign res_o.out_x  = ox_q;
  assign res_o.out_y  = oy_q;

endmodule

// ----- src/analog_stick_deadzone_events.sv -----
// Top level of the analog stick radial dead-zone and event block.
`timescale 1ns / 1ps

// Usage: each transaction on in_i carries one X/Y sample of one stick; the
// block answers every sample with exactly one transaction on out_o holding the
// stick, the conditioned X and Y values in Q2.14 and a down, move or up event.
// The dead zones of the left stick and of every other stick are to be written through
// cfg_we_i, cfg_idx_i and cfg_data_i while the block is idle; the block does not enforce this.
// One sample is worked at a time. A sample that falls inside the dead zone
// skips the scaling steps after the magnitude; a sample outside it runs them,
// and an axis that saturates early skips its division steps. The steps run
// one after another on the shared subtract unit of the engine: 15 square
// root steps for the magnitude and 17 division steps per axis.
// in_i.ready is high whenever no sample is in the engine, so a new sample is
// taken while the previous result still sits in the output register. If the
// receiver stalls, the engine finishes and holds its result until the output
// register frees up, and no further sample is taken meanwhile.
// Reset clears the per-stick history, sets both dead zones to 2621 (about
// 0.16) and empties the output register.

module analog_stick_deadzone_events #(
  parameter int NUM_STICKS = 2
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  asde_stream_if.sink                          in_i,
  asde_stream_if.source                        out_o,
  input  logic                                 cfg_we_i,
  input  logic [asde_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [asde_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import asde_pkg::*;

  localparam int IdxW = (NUM_STICKS > 1) ? $clog2(NUM_STICKS) : 1;

  logic [DZ_W-1:0] dz_left_q, dz_right_q;
  logic            busy_q;
  logic            sel_q;
  logic [1:0]      hist_q [NUM_STICKS];
  out_item_t       out_q;
  logic            out_valid_q;

  logic            in_sel;
  logic            start;
  eng_req_t        eng_req;
  eng_res_t        eng_res;
  logic            eng_done;
  logic            eng_ack;
  logic            load;
  logic [IdxW-1:0] hidx;
  logic            cur, prev, prev2;
  evt_kind_e       ev;

  // Configuration registers. Writes to unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_left_q  <= DZ_RESET;
      dz_right_q <= DZ_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DZ_LEFT:  dz_left_q  <= cfg_data_i;
        REG_DZ_RIGHT: dz_right_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // A selector that names a stick the block does not have maps to stick 0.
  assign in_sel = (32'(in_i.payload.stick_select) < NUM_STICKS) ?
                  in_i.payload.stick_select : 1'b0;

  assign in_i.ready = ~busy_q;
  assign start      = in_i.valid & ~busy_q;

  assign eng_req.raw_x = in_i.payload.raw_x;
  assign eng_req.raw_y = in_i.payload.raw_y;
  assign eng_req.dz    = in_sel ? dz_right_q : dz_left_q;

  asde_engine u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .req_i   (eng_req),
    .ack_i   (eng_ack),
    .done_o  (eng_done),
    .res_o   (eng_res)
  );

  // The engine hands over its result once the output register is free.
  assign eng_ack = ~out_valid_q | out_o.ready;
  assign load    = eng_done & eng_ack;

  // Event classification from this output and the stick's last two.
  assign hidx  = IdxW'(sel_q);
  assign cur   = (eng_res.out_x != '0) || (eng_res.out_y != '0);
  assign prev  = hist_q[hidx][0];
  assign prev2 = hist_q[hidx][1];

  always_comb begin
    if (!cur && !prev && prev2) begin
      ev = EV_UP;
    end else if (cur && !prev && !prev2) begin
      ev = EV_DOWN;
    end else begin
      ev = EV_MOVE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_STICKS; i++) begin
        hist_q[i] <= 2'b00;
      end
    end else begin
      if (start) begin
        busy_q <= 1'b1;
      end else if (load) begin
        busy_q <= 1'b0;
      end
      if (load) begin
        out_valid_q  <= 1'b1;
        hist_q[hidx] <= {prev, cur};
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      sel_q <= in_sel;
    end
    if (load) begin
      out_q.stick_out  <= sel_q;
      out_q.out_x      <= eng_res.out_x;
      out_q.out_y      <= eng_res.out_y;
      out_q.event_kind <= ev;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // The engine only reports a result for a sample it was given.
  a_done_when_busy : assert property (
    @(posedge clk_i) disable iff (!rst_ni) eng_done |-> busy_q)
    else $error("engine finished without a sample in flight");

  // A result that cannot be handed over is held by the engine.
  a_engine_holds : assert property (
    @(posedge clk_i) disable iff (!rst_ni) (eng_done && !eng_ack) |=> eng_done)
    else $error("engine dropped a result while the output was stalled");

  // Up events come only with zero outputs, down events only with a nonzero one.
  a_up_is_zero : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.event_kind == EV_UP)) |->
    ((out_q.out_x == '0) && (out_q.out_y == '0)))
    else $error("up event with a nonzero output");

  a_down_is_nonzero : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.event_kind == EV_DOWN)) |->
    ((out_q.out_x != '0) || (out_q.out_y != '0)))
    else $error("down event with a zero output");

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the analog stick dead-zone and event block.
`timescale 1ns / 1ps

import asde_pkg::*;

// Tracks the dead zones and the per-stick press history, predicts the
// conditioned output of every accepted sample and compares results in order.
class stick_scoreboard;
  logic [DZ_W-1:0] dz_left;
  logic [DZ_W-1:0] dz_right;
  logic [1:0]      history[];
  out_item_t       expected_q[$];
  int unsigned     mismatches;
  int unsigned     results_seen;
  int unsigned     event_count[3];

  function new(int sticks);
    dz_left  = DZ_RESET;
    dz_right = DZ_RESET;
    history  = new[sticks];
    foreach (history[i]) history[i] = 2'b00;
  endfunction

  function void set_deadzone(logic [CFG_IDX_W-1:0] idx, logic [DZ_W-1:0] value);
    case (idx)
      REG_DZ_LEFT: begin
        dz_left = value;
      end
      REG_DZ_RIGHT: begin
        dz_right = value;
      end
      default: begin
      end
    endcase
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Largest root whose square does not exceed v; v stays below 2^30 here.
  function longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 16; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // One axis: direction times the rescaled magnitude, rounded half away from
  // zero, then clipped to the signed 16-bit range.
  function logic [OUT_W-1:0] scale_axis(int c, longint unsigned mag,
                                        longint unsigned dz);
    longint unsigned a;
    longint unsigned num;
    longint unsigned den;
    longint unsigned q;
    a   = (c < 0) ? longint'(-c) : longint'(c);
    num = a * 64'd16384 * 64'd128 * (mag - dz);
    den = mag * (64'd16384 - dz);
    q   = (num + den / 2) / den;
    if (c < 0) begin
      if (q > 64'd32768) q = 64'd32768;
      return OUT_W'(64'd0 - q);
    end
    if (q > 64'd32767) q = 64'd32767;
    return OUT_W'(q);
  endfunction

  function void note_sample(in_item_t s);
    int unsigned     sel;
    int              cx;
    int              cy;
    longint unsigned dz;
    longint unsigned mag;
    logic            cur;
    logic            prev;
    logic            prev2;
    out_item_t       want;
    sel = s.stick_select;
    if (sel >= history.size()) sel = 0;
    dz  = (sel == 0) ? dz_left : dz_right;
    cx  = int'(s.raw_x) - 128;
    cy  = int'(s.raw_y) - 128;
    mag = int_sqrt(longint'(cx * cx + cy * cy) << 14);
    want.stick_out = sel[0];
    want.out_x     = '0;
    want.out_y     = '0;
    // A centered stick with no dead zone has no direction, so it stays zero.
    if (mag >= dz && mag != 0) begin
      want.out_x = scale_axis(cx, mag, dz);
      want.out_y = scale_axis(cy, mag, dz);
    end
    cur   = (want.out_x != 0) || (want.out_y != 0);
    prev  = history[sel][0];
    prev2 = history[sel][1];
    if (!cur && !prev && prev2) want.event_kind = EV_UP;
    else if (cur && !prev && !prev2) want.event_kind = EV_DOWN;
    else want.event_kind = EV_MOVE;
    history[sel] = {prev, cur};
    expected_q.push_back(want);
  endfunction

  function void check_result(out_item_t got);
    out_item_t want;
    if (expected_q.size() == 0) begin
      $error("result on stick %0d arrived with no sample outstanding", got.stick_out);
      mismatches++;
      return;
    end
    want = expected_q.pop_front();
    results_seen++;
    event_count[int'(want.event_kind)]++;
    if (got.stick_out !== want.stick_out) begin
      $error("stick_out: expected %0d, actual %0d", want.stick_out, got.stick_out);
      mismatches++;
    end
    if (got.out_x !== want.out_x) begin
      $error("out_x: expected %0d, actual %0d", want.out_x, got.out_x);
      mismatches++;
    end
    if (got.out_y !== want.out_y) begin
      $error("out_y: expected %0d, actual %0d", want.out_y, got.out_y);
      mismatches++;
    end
    if (got.event_kind !== want.event_kind) begin
      $error("event_kind: expected %0d, actual %0d", want.event_kind, got.event_kind);
      mismatches++;
    end
  endfunction
endclass

module testbench;

  localparam int          NUM_STICKS    = 2;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned CHUNK_SAMPLES = 250;
  localparam logic        STICK_L       = 1'b0;
  localparam logic        STICK_R       = 1'b1;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  asde_stream_if #(.payload_t(in_item_t))  sample_ch ();
  asde_stream_if #(.payload_t(out_item_t)) result_ch ();

  stick_scoreboard book = new(NUM_STICKS);

  // Idle percentages of the two sides and the request for a long receiver
  // hold-off; the main process sets them, the driving processes read them.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_request  = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned samples_sent  = 0;
  int unsigned settings_used = 0;
  int unsigned cycles        = 0;

  analog_stick_deadzone_events #(
    .NUM_STICKS(NUM_STICKS)
  ) i_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_i      (sample_ch),
    .out_o     (result_ch),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  always #5 clk = ~clk;

  // Watchdog: a healthy run finishes far below this bound even with the
  // heaviest idling, so reaching it means the block hung.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side. Each transaction seen at an edge is checked against the
  // oldest prediction; ready is then chosen for the next edge, either from
  // the idle percentage or held low for a long stretch on request.
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (result_ch.valid && result_ch.ready) book.check_result(result_ch.payload);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic in_item_t make_sample(logic stick, logic [RAW_W-1:0] x,
                                           logic [RAW_W-1:0] y);
    in_item_t s;
    s.stick_select = stick;
    s.raw_x        = x;
    s.raw_y        = y;
    return s;
  endfunction

  function automatic logic [RAW_W-1:0] clamp_raw(int v);
    if (v < 0) return '0;
    if (v > 255) return 8'd255;
    return RAW_W'(v);
  endfunction

  // A resting sample: each axis stays within half the dead-zone radius of
  // center, so the magnitude is always below the dead zone (or exactly zero).
  function automatic in_item_t rest_sample(logic stick, int reach);
    int r;
    r = reach / 2;
    return make_sample(stick, clamp_raw(128 + int'($urandom_range(2 * r)) - r),
                       clamp_raw(128 + int'($urandom_range(2 * r)) - r));
  endfunction

  // A deflected sample: usually anywhere on the square, sometimes one axis
  // right at the dead-zone edge, where the output may round to zero.
  function automatic in_item_t pressed_sample(logic stick, int reach);
    int off;
    if ($urandom_range(9) == 0) begin
      off = reach - 1 + int'($urandom_range(2));
      if ($urandom_range(1) == 1) off = -off;
      if ($urandom_range(1) == 1) return make_sample(stick, clamp_raw(128 + off), 8'd128);
      return make_sample(stick, 8'd128, clamp_raw(128 + off));
    end
    return make_sample(stick, RAW_W'($urandom_range(255)), RAW_W'($urandom_range(255)));
  endfunction

  // Offers one sample, idling beforehand at the current rate, and returns at
  // the edge where the transaction completes. Valid stays high into the next
  // call so back-to-back samples need no gap.
  task automatic send_sample(in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid   <= 1'b1;
    sample_ch.payload <= item;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    book.note_sample(item);
    samples_sent++;
  endtask

  // Stops offering and waits until every predicted result has been taken.
  task automatic wait_drained();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (book.pending() != 0) @(posedge clk);
  endtask

  // Writes both dead zones on consecutive edges; only called when drained.
  task automatic set_deadzones(logic [DZ_W-1:0] left, logic [DZ_W-1:0] right);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_DZ_LEFT;
    cfg_data <= left;
    @(posedge clk);
    cfg_idx  <= REG_DZ_RIGHT;
    cfg_data <= right;
    @(posedge clk);
    cfg_we <= 1'b0;
    book.set_deadzone(REG_DZ_LEFT, left);
    book.set_deadzone(REG_DZ_RIGHT, right);
    settings_used++;
  endtask

  // One touch on a random stick: some rest, a press of a few samples, then
  // rest again, so down, move and up events all occur, interleaved between
  // the two sticks.
  task automatic play_gesture();
    logic        stick;
    int          reach;
    int unsigned n_lead;
    int unsigned n_press;
    int unsigned n_tail;
    stick   = 1'($urandom_range(1));
    reach   = int'((stick ? book.dz_right : book.dz_left) >> 7);
    n_lead  = $urandom_range(2);
    n_press = $urandom_range(5, 1);
    n_tail  = $urandom_range(3);
    repeat (n_lead) send_sample(rest_sample(stick, reach));
    repeat (n_press) send_sample(pressed_sample(stick, reach));
    repeat (n_tail) send_sample(rest_sample(stick, reach));
  endtask

  // Random traffic until the chunk's share of samples has gone in; about
  // one item in seven is unrelated noise on either stick.
  task automatic random_chunk();
    int unsigned goal;
    goal = samples_sent + CHUNK_SAMPLES;
    while (samples_sent < goal) begin
      if ($urandom_range(99) < 15) begin
        send_sample(make_sample(1'($urandom_range(1)), RAW_W'($urandom_range(255)),
                                RAW_W'($urandom_range(255))));
      end else begin
        play_gesture();
      end
    end
  endtask

  initial begin
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= REG_DZ_LEFT;
    cfg_data          <= '0;
    sample_ch.valid   <= 1'b0;
    sample_ch.payload <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part with the reset dead zones: an idle sample, a full press
    // and release on the left stick (down, move, move, move, up), the four corners
    // and the axis extremes, a sample inside the dead zone and a checkerboard
    // pattern on the raw bits.
    send_sample(make_sample(STICK_L, 8'd128, 8'd128));
    send_sample(make_sample(STICK_L, 8'd255, 8'd128));
    send_sample(make_sample(STICK_L, 8'd255, 8'd255));
    send_sample(make_sample(STICK_L, 8'd0, 8'd0));
    send_sample(make_sample(STICK_L, 8'd128, 8'd128));
    send_sample(make_sample(STICK_L, 8'd128, 8'd128));
    send_sample(make_sample(STICK_R, 8'd0, 8'd255));
    send_sample(make_sample(STICK_R, 8'd255, 8'd0));
    send_sample(make_sample(STICK_R, 8'd140, 8'd128));
    send_sample(make_sample(STICK_R, 8'd128, 8'd0));
    send_sample(make_sample(STICK_L, 8'hAA, 8'h55));
    send_sample(make_sample(STICK_L, 8'h55, 8'hAA));
    send_sample(make_sample(STICK_R, 8'd127, 8'd127));
    send_sample(make_sample(STICK_R, 8'd128, 8'd128));
    send_sample(make_sample(STICK_R, 8'd128, 8'd128));
    wait_drained();

    // No dead zone on the left, so the centered sample has no direction; on
    // the right the smallest nonzero magnitude sits exactly on the dead zone
    // and must still produce zero.
    set_deadzones(14'd0, 14'd128);
    send_sample(make_sample(STICK_L, 8'd128, 8'd128));
    send_sample(make_sample(STICK_L, 8'd129, 8'd128));
    send_sample(make_sample(STICK_R, 8'd129, 8'd128));
    send_sample(make_sample(STICK_R, 8'd128, 8'd127));
    send_sample(make_sample(STICK_R, 8'd130, 8'd128));
    wait_drained();

    // Largest dead zone: the corners stretch far beyond full scale and both
    // axes saturate, positive and negative.
    set_deadzones(14'd16383, 14'd16383);
    send_sample(make_sample(STICK_L, 8'd0, 8'd0));
    send_sample(make_sample(STICK_L, 8'd255, 8'd255));
    send_sample(make_sample(STICK_R, 8'd0, 8'd255));
    send_sample(make_sample(STICK_R, 8'd255, 8'd0));
    send_sample(make_sample(STICK_L, 8'd128, 8'd0));
    send_sample(make_sample(STICK_R, 8'd0, 8'd128));
    wait_drained();

    // Random part. The sender idles a third of the time while the receiver
    // idles three quarters, then the other way round, then neither idles.
    send_idle_pct = 33;
    recv_idle_pct = 75;
    set_deadzones(DZ_W'($urandom_range(16383)), DZ_W'($urandom_range(16383)));
    random_chunk();
    wait_drained();
    set_deadzones(14'd0, 14'd16383);
    random_chunk();
    wait_drained();

    send_idle_pct = 75;
    recv_idle_pct = 33;
    set_deadzones(14'd16383, 14'd0);
    random_chunk();
    wait_drained();
    set_deadzones(DZ_W'($urandom_range(4000)), DZ_W'($urandom_range(16383)));
    random_chunk();
    wait_drained();

    // Back-pressure: the receiver stops for a long stretch while samples keep
    // coming, so the engine and output register fill and input ready drops.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_deadzones(DZ_RESET, DZ_RESET);
    hold_request = 1'b1;
    random_chunk();
    wait_drained();

    // Last two chunks, with one pause of the sender between them until the block has emptied.
    set_deadzones(DZ_W'($urandom_range(16383)), DZ_W'($urandom_range(16383)));
    random_chunk();
    wait_drained();
    random_chunk();
    wait_drained();

    // Allow any stray result to show up before judging the run.
    repeat (100) @(posedge clk);

    $display("Sent %0d samples under %0d dead-zone settings; %0d results checked.",
             samples_sent, settings_used, book.results_seen);
    $display("Events seen: %0d down, %0d move, %0d up; %0d mismatches.",
             book.event_count[EV_DOWN], book.event_count[EV_MOVE],
             book.event_count[EV_UP], book.mismatches);
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/asde_pkg.sv
src/asde_stream_if.sv
src/asde_engine.sv
src/analog_stick_deadzone_events.sv
test/testbench.sv
